>>> design/max_empty_rectangle_grid_unit_macros.svh
// Assertion macros for the grid unit RTL.
// Included by merg_dp, the module that carries concurrent checks.
`ifndef MAX_EMPTY_RECTANGLE_GRID_UNIT_MACROS_SVH
`define MAX_EMPTY_RECTANGLE_GRID_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MERG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MERG_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MERG_ASSERT(label, clk, rst, prop, msg)
`define MERG_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> design/merg_pkg.sv
// Shared types and constants for the max empty rectangle grid unit.
// No dependencies.
package merg_pkg;
  localparam int MaxCols = 4096;
  localparam int MaxRows = 4096;
  localparam int ColW    = $clog2(MaxCols);
  localparam int RowW    = $clog2(MaxRows);
  localparam int ExtW    = 13;
  localparam int AreaW   = 25;
  localparam logic [AreaW-1:0] AreaMax = '1;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  typedef struct packed {
    logic          clr_start;   // begin clearing sweep
    logic          fwd;         // accept and process one cell
    logic          bwd_start;   // start the right-to-left pass
    logic          bwd;         // one backward step
    logic          emit;        // load result register
  } merg_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic row_end;    // accepted cell was last of its row
    logic grid_end;   // accepted cell lies in the grid's last row
    logic bwd_done;   // backward pass has drained
  } merg_sts_t;

  function automatic logic [ExtW-1:0] tighten(input logic [ExtW-1:0] ext,
                                               input logic [ExtW-1:0] run);
    if (ext == '0) return run;
    return (ext < run) ? ext : run;
  endfunction
endpackage

>>> design/merg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module merg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> design/merg_ctrl.sv
// Controller state machine of the grid unit.
// Depends on merg_pkg.
module merg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_busy,
  input  merg_pkg::merg_sts_t sts,
  output merg_pkg::merg_cmd_t cmd
);
  import merg_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_FWD  = 3'd1;
  localparam logic [2:0] S_BWD  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_INIT = 3'd4;

  logic [2:0] state, state_next;
  logic       last_row;
  logic       last_row_next;

  always_comb begin
    state_next    = state;
    last_row_next = last_row;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.clr_start = 1'b1;
        state_next    = S_CLR;
      end
      S_CLR: begin
        if (sts.clr_done) state_next = S_FWD;
      end
      S_FWD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.fwd = 1'b1;
          if (sts.row_end) begin
            cmd.bwd_start = 1'b1;
            last_row_next = sts.grid_end;
            state_next    = S_BWD;
          end
        end
      end
      S_BWD: begin
        cmd.bwd = 1'b1;
        if (sts.bwd_done) begin
          cmd.bwd = 1'b0;
          state_next = last_row ? S_EMIT : S_FWD;
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          cmd.emit      = 1'b1;
          cmd.clr_start = 1'b1;
          state_next    = S_CLR;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      last_row <= 1'b0;
    end else begin
      state    <= state_next;
      last_row <= last_row_next;
    end
  end
endmodule

>>> design/merg_dp.sv
// Datapath of the grid unit: column stores, forward update, backward pass.
// Depends on merg_pkg and merg_ram.
`include "max_empty_rectangle_grid_unit_macros.svh"
module merg_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  merg_pkg::merg_cmd_t        cmd,
  output merg_pkg::merg_sts_t        sts,
  input  logic                       blocked,
  input  logic [merg_pkg::ExtW-1:0]  rows_eff,
  input  logic [merg_pkg::ExtW-1:0]  cols_eff,
  output logic [merg_pkg::AreaW-1:0] best_area
);
  import merg_pkg::*;

  // position and clear sweep
  logic [ColW-1:0] col_pos;
  logic [RowW-1:0] row_pos;
  logic [ExtW-1:0] left_run;
  logic            clearing;
  logic [ColW-1:0] clr_addr;

  // backward pass pipeline: read issue, data, product
  logic [ColW:0]   bj;       // columns still to read
  logic            v1, v3;
  logic [ColW-1:0] a1, a2;
  logic [ExtW-1:0] rrun;
  logic [ExtW-1:0] h2, ext2;
  logic            b2;
  logic [2*ExtW-1:0] prod3;

  // RAM ports
  logic            h_we, l_we, r_we, b_we;
  logic [ColW-1:0] h_wa, l_wa, r_wa, b_wa, rd_a;
  logic [ExtW-1:0] h_wd, l_wd, r_wd, h_rd, l_rd, r_rd;
  logic            b_wd, b_rd;

  logic [ExtW-1:0] h_new, l_new, lrun_new, rnew;
  logic [ColW:0]   c_inc;
  logic [RowW:0]   r_inc;
  logic [ExtW:0]   span;

  // forward path needs stored h and l of the arriving column; keep them
  // pre-read: on an accepted word the read port moves to the next column,
  // otherwise it points at col_pos while not in the backward pass
  assign rd_a = (bj != '0) ? bj[ColW-1:0] - 1'b1 :
                cmd.fwd    ? c_inc[ColW-1:0] : col_pos;

  merg_ram #(.Width(ExtW), .Depth(MaxCols)) u_h (
    .clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(rd_a), .rdata(h_rd));
  merg_ram #(.Width(ExtW), .Depth(MaxCols)) u_l (
    .clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(rd_a), .rdata(l_rd));
  merg_ram #(.Width(ExtW), .Depth(MaxCols)) u_r (
    .clk, .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(rd_a), .rdata(r_rd));
  merg_ram #(.Width(1), .Depth(MaxCols)) u_b (
    .clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(rd_a), .rdata(b_rd));

  // forward cell update
  always_comb begin
    lrun_new = blocked ? '0 : left_run + 1'b1;
    h_new    = blocked ? '0 : h_rd + 1'b1;
    l_new    = blocked ? '0 : tighten(l_rd, lrun_new);
    c_inc    = {1'b0, col_pos} + 1'b1;
    r_inc    = {1'b0, row_pos} + 1'b1;
    sts.row_end  = (ExtW'(c_inc) >= cols_eff);
    sts.grid_end = (ExtW'(r_inc) >= rows_eff);
    sts.clr_done = clearing && (clr_addr == ColW'(MaxCols-1));
    sts.bwd_done = (bj == '0) && !v1 && !v3;
    rnew = b2 ? '0 : tighten(r_rd, rrun + 1'b1);
    span = {1'b0, l_rd} + {1'b0, rnew} - 1'b1;
  end

  // store write muxes: clearing, forward, backward right extent
  always_comb begin
    h_we = clearing || cmd.fwd;
    l_we = h_we;
    b_we = h_we;
    h_wa = clearing ? clr_addr : col_pos;
    l_wa = h_wa;
    b_wa = h_wa;
    h_wd = clearing ? '0 : h_new;
    l_wd = clearing ? '0 : l_new;
    b_wd = clearing ? 1'b0 : blocked;
    r_we = clearing || v1;
    r_wa = clearing ? clr_addr : a2;
    r_wd = clearing ? '0 : rnew;
  end

  // column and row counters, clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b0;
      clr_addr <= '0;
      col_pos  <= '0;
      row_pos  <= '0;
      left_run <= '0;
    end else begin
      if (cmd.clr_start) begin
        clearing <= 1'b1;
        clr_addr <= '0;
        col_pos  <= '0;
        row_pos  <= '0;
        left_run <= '0;
      end else if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (sts.clr_done) clearing <= 1'b0;
      end
      if (cmd.fwd) begin
        if (sts.row_end) begin
          col_pos  <= '0;
          left_run <= '0;
          row_pos  <= sts.grid_end ? row_pos : row_pos + 1'b1;
        end else begin
          col_pos  <= col_pos + 1'b1;
          left_run <= lrun_new;
        end
      end
    end
  end

  // backward pass: read issue, evaluate, multiply, compare
  always_ff @(posedge clk) begin
    if (rst) begin
      bj <= '0;
      v1 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= 1'b0;
      if (cmd.bwd_start) begin
        bj <= cols_eff[ColW:0];
      end else if (cmd.bwd && bj != '0) begin
        bj <= bj - 1'b1;
        v1 <= 1'b1;
      end
      v3 <= v1 && !b2;
    end
  end

  // v1 stage sees RAM data of column a1; a2 is its write-back address
  assign a2 = a1;
  assign b2 = b_rd;
  assign h2 = h_rd;
  assign ext2 = span[ExtW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.bwd_start) rrun <= '0;
    else if (v1) rrun <= b2 ? '0 : rrun + 1'b1;
    if (cmd.bwd && bj != '0) a1 <= rd_a;
    if (v1) begin
      // span fits 13 bits: left and right each at most cols
      prod3 <= h2 * ext2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      best_area <= '0;
    end else if (v3) begin
      if (prod3 > {{(2*ExtW-AreaW){1'b0}}, AreaMax}) begin
        if (AreaMax > best_area) best_area <= AreaMax;
      end else if (prod3[AreaW-1:0] > best_area) begin
        best_area <= prod3[AreaW-1:0];
      end
    end
  end

  `MERG_ASSERT(a_no_fwd_in_bwd, clk, rst, cmd.fwd |-> (bj == '0 && !v1 && !v3), "fwd during pass")
  `MERG_ASSERT(a_no_fwd_clr, clk, rst, cmd.fwd |-> !clearing, "fwd during clear")
  `MERG_ASSERT(a_v_chain, clk, rst, v3 |-> $past(v1), "pipe valid broken")
endmodule

>>> design/max_empty_rectangle_grid_unit.sv
// Largest empty rectangle over a streamed binary grid. Cells arrive in raster
// order, one word per cycle while a row streams in; after each row the unit
// makes a right-to-left pass through the column stores. After the grid's
// last row the area is presented on the output register and the column
// stores are swept clear, during which no cell is taken; the same sweep
// runs after reset.
// Depends on merg_pkg, merg_ctrl, merg_dp.
module max_empty_rectangle_grid_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       blocked,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [merg_pkg::AreaW-1:0] area,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [merg_pkg::ExtW-1:0]  cfg_data
);
  import merg_pkg::*;

  logic [ExtW-1:0]  rows, cols, rows_eff, cols_eff;
  logic [AreaW-1:0] best_area;
  merg_cmd_t        cmd;
  merg_sts_t        sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= ExtW'(1);
      cols <= ExtW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: rows <= cfg_data;
        REG_COLS: cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, above maximum clamps
  always_comb begin
    rows_eff = (rows == '0) ? ExtW'(1) : (rows > ExtW'(MaxRows)) ? ExtW'(MaxRows) : rows;
    cols_eff = (cols == '0) ? ExtW'(1) : (cols > ExtW'(MaxCols)) ? ExtW'(MaxCols) : cols;
  end

  merg_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_busy(out_valid && !out_ready),
    .sts, .cmd);

  merg_dp u_dp (
    .clk, .rst, .cmd, .sts, .blocked, .rows_eff, .cols_eff, .best_area);

  // result word register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.emit) area <= best_area;
  end
endmodule

>>> tb/tb_max_empty_rectangle_grid_unit.sv
// Self-checking testbench for max_empty_rectangle_grid_unit: streams grids of cells,
// predicts the largest empty rectangle per grid and checks every area word.
// Depends on merg_pkg and the max_empty_rectangle_grid_unit RTL.
module tb_max_empty_rectangle_grid_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import merg_pkg::*;

  // Expected-area tracker: mirrors the per-column stores of the unit
  class area_scoreboard;
    int unsigned col_height[MaxCols];
    int unsigned left_ext[MaxCols];
    int unsigned right_ext[MaxCols];
    bit          row_cells[MaxCols];
    int unsigned left_len;
    int unsigned best;
    int unsigned col_at;
    int unsigned row_at;
    logic [ExtW-1:0] rows_reg;
    logic [ExtW-1:0] cols_reg;
    logic [AreaW-1:0] pending_areas[$];
    int errors;

    function new();
      rows_reg = 1;
      cols_reg = 1;
      errors = 0;
      clear_grid();
    endfunction

    function void clear_grid();
      for (int i = 0; i < MaxCols; i++) begin
        col_height[i] = 0;
        left_ext[i] = 0;
        right_ext[i] = 0;
        row_cells[i] = 0;
      end
      left_len = 0;
      best = 0;
      col_at = 0;
      row_at = 0;
    endfunction

    // zero extent means unconstrained: take the run length
    function int unsigned narrow_extent(int unsigned ext, int unsigned run);
      if (ext == 0) return run;
      return (ext < run) ? ext : run;
    endfunction

    function int unsigned effective(logic [ExtW-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    // right-to-left sweep over the finished row
    function void sweep_row(int unsigned ncols);
      int unsigned run;
      longint unsigned a;
      run = 0;
      for (int j = ncols - 1; j >= 0; j--) begin
        if (row_cells[j]) begin
          run = 0;
          right_ext[j] = 0;
        end else begin
          run++;
          right_ext[j] = narrow_extent(right_ext[j], run);
          a = longint'(col_height[j]) * longint'(left_ext[j] + right_ext[j] - 1);
          if (a > AreaMax) a = AreaMax;
          if (a > best) best = a;
        end
      end
    endfunction

    function void note_cell(bit b);
      int unsigned ncols;
      int unsigned nrows;
      int unsigned c;
      ncols = effective(cols_reg, MaxCols);
      nrows = effective(rows_reg, MaxRows);
      c = (col_at >= MaxCols) ? MaxCols - 1 : col_at;
      row_cells[c] = b;
      if (b) begin
        col_height[c] = 0;
        left_ext[c] = 0;
        left_len = 0;
      end else begin
        col_height[c]++;
        left_len++;
        left_ext[c] = narrow_extent(left_ext[c], left_len);
      end
      if (c + 1 < ncols) begin
        col_at = c + 1;
        return;
      end
      sweep_row(ncols);
      left_len = 0;
      col_at = 0;
      if (row_at + 1 < nrows) begin
        row_at++;
        return;
      end
      pending_areas.push_back(best);
      clear_grid();
    endfunction

    function void check_area(logic [AreaW-1:0] got);
      logic [AreaW-1:0] want;
      if (pending_areas.size() == 0) begin
        $display("%0t: unexpected area word, expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = pending_areas.pop_front();
      if (got !== want) begin
        $display("%0t: area mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic blocked;
  logic out_valid;
  logic out_ready;
  logic [AreaW-1:0] area;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [ExtW-1:0] cfg_data;

  area_scoreboard grid_sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int cells_sent;
  int grids_done;

  bit grid_pat[12] = '{0, 0, 1, 0,
                       0, 0, 0, 0,
                       1, 0, 0, 0};

  max_empty_rectangle_grid_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .blocked(blocked),
    .out_valid(out_valid), .out_ready(out_ready), .area(area),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check each accepted word, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) grid_sb.check_area(area);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one cell word and hold it until taken; maybe idle afterwards
  task automatic send_cell(bit b);
    in_valid <= 1'b1;
    blocked <= b;
    do @(posedge clk); while (!in_ready);
    grid_sb.note_cell(b);
    cells_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Register writes only once all areas are back and the clear sweep is over
  task automatic write_reg(logic [1:0] idx, logic [ExtW-1:0] val);
    in_valid <= 1'b0;
    while (grid_sb.pending_areas.size() != 0) @(posedge clk);
    repeat (MaxCols + 100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROWS) grid_sb.rows_reg = val;
    else grid_sb.cols_reg = val;
  endtask

  task automatic send_grid(int unsigned ncells, int blk_pct);
    for (int unsigned i = 0; i < ncells; i++) send_cell($urandom_range(99) < blk_pct);
    grids_done++;
  endtask

  function automatic int unsigned eff_size(logic [ExtW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxCols) return MaxCols;
    return v;
  endfunction

  task automatic random_grid(int idx);
    logic [ExtW-1:0] r;
    logic [ExtW-1:0] c;
    int pick;
    int pct;
    pick = $urandom_range(5);
    pct = (pick == 0) ? 0 : (pick == 1) ? 100 : (pick == 2) ? 10 : $urandom_range(60);
    r = $urandom_range(8);
    c = $urandom_range(8);
    // a few long one-dimensional grids
    if (idx == 6) begin
      r = 1;
      c = 64;
    end else if (idx == 20) begin
      r = 64;
      c = 0;
    end else if (idx == 33) begin
      r = 0;
      c = 64;
    end
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, c);
    send_grid(eff_size(r) * eff_size(c), pct);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    blocked <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_ROWS;
    cfg_data <= '0;
    send_idle_pct = 28;
    recv_stall_pct = 81;
    cells_sent = 0;
    grids_done = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: default 1x1 free and blocked
    send_cell(1'b0);
    send_cell(1'b1);
    // zero-size registers behave as one
    write_reg(REG_ROWS, 0);
    write_reg(REG_COLS, 0);
    send_cell(1'b0);
    // 3x4 with a few obstacles
    write_reg(REG_ROWS, 3);
    write_reg(REG_COLS, 4);
    foreach (grid_pat[i]) send_cell(grid_pat[i]);
    // 2x2 all blocked
    write_reg(REG_ROWS, 2);
    write_reg(REG_COLS, 2);
    repeat (4) send_cell(1'b1);

    // Random grids, three idle profiles
    for (int g = 0; cells_sent < 1100 || g < 45; g++) begin
      if (g == 15) begin
        send_idle_pct = 81;
        recv_stall_pct = 28;
      end else if (g == 30) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      random_grid(g);
    end
    in_valid <= 1'b0;

    while (grid_sb.pending_areas.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (grid_sb.errors == 0) $display("max_empty_rectangle_grid_unit: match");
    else $display("max_empty_rectangle_grid_unit: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #60ms;
    $display("max_empty_rectangle_grid_unit: mismatch");
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/merg_pkg.sv
design/merg_ram.sv
design/merg_ctrl.sv
design/merg_dp.sv
design/max_empty_rectangle_grid_unit.sv
tb/tb_max_empty_rectangle_grid_unit.sv
